>>> src/ppg_pkg.sv
// shared constants, sine table and hue-to-rgb565 function for the plasma pixel generator
`default_nettype none
package ppg_pkg;

    localparam int unsigned COORD_W  = 8;
    localparam int unsigned TIME_W   = 10;
    localparam int unsigned WIDTH_W  = 9;
    localparam int unsigned COLOR_W  = 16;
    localparam int unsigned ADDR_W   = 16;
    localparam int unsigned PROD_W   = COORD_W + WIDTH_W;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 9'd256;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 9'd240;
    localparam logic [7:0] HUE_SECTOR   = 8'd43;
    localparam logic [7:0] FULL_SCALE   = 8'd255;

    typedef enum logic [2:0] {
        SEC_RED_GREEN  = 3'd0,
        SEC_GREEN_RED  = 3'd1,
        SEC_GREEN_BLUE = 3'd2,
        SEC_BLUE_GREEN = 3'd3,
        SEC_BLUE_RED   = 3'd4,
        SEC_RED_BLUE   = 3'd5
    } t_sector;

    localparam logic [7:0] SINE_ROM [256] = '{
        8'd127,8'd130,8'd133,8'd136,8'd139,8'd143,8'd146,8'd149,
        8'd152,8'd155,8'd158,8'd161,8'd164,8'd167,8'd170,8'd173,
        8'd176,8'd179,8'd182,8'd184,8'd187,8'd190,8'd193,8'd195,
        8'd198,8'd200,8'd203,8'd205,8'd208,8'd210,8'd213,8'd215,
        8'd217,8'd219,8'd221,8'd224,8'd226,8'd228,8'd229,8'd231,
        8'd233,8'd235,8'd236,8'd238,8'd239,8'd241,8'd242,8'd244,
        8'd245,8'd246,8'd247,8'd248,8'd249,8'd250,8'd251,8'd251,
        8'd252,8'd253,8'd253,8'd254,8'd254,8'd254,8'd254,8'd254,
        8'd255,8'd254,8'd254,8'd254,8'd254,8'd254,8'd253,8'd253,
        8'd252,8'd251,8'd251,8'd250,8'd249,8'd248,8'd247,8'd246,
        8'd245,8'd244,8'd242,8'd241,8'd239,8'd238,8'd236,8'd235,
        8'd233,8'd231,8'd229,8'd228,8'd226,8'd224,8'd221,8'd219,
        8'd217,8'd215,8'd213,8'd210,8'd208,8'd205,8'd203,8'd200,
        8'd198,8'd195,8'd193,8'd190,8'd187,8'd184,8'd182,8'd179,
        8'd176,8'd173,8'd170,8'd167,8'd164,8'd161,8'd158,8'd155,
        8'd152,8'd149,8'd146,8'd143,8'd139,8'd136,8'd133,8'd130,
        8'd127,8'd124,8'd121,8'd118,8'd115,8'd111,8'd108,8'd105,
        8'd102,8'd99, 8'd96, 8'd93, 8'd90, 8'd87, 8'd84, 8'd81,
        8'd78, 8'd75, 8'd72, 8'd70, 8'd67, 8'd64, 8'd61, 8'd59,
        8'd56, 8'd54, 8'd51, 8'd49, 8'd46, 8'd44, 8'd41, 8'd39,
        8'd37, 8'd35, 8'd33, 8'd30, 8'd28, 8'd26, 8'd25, 8'd23,
        8'd21, 8'd19, 8'd18, 8'd16, 8'd15, 8'd13, 8'd12, 8'd10,
        8'd9,  8'd8,  8'd7,  8'd6,  8'd5,  8'd4,  8'd3,  8'd3,
        8'd2,  8'd1,  8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd1,  8'd1,
        8'd2,  8'd3,  8'd3,  8'd4,  8'd5,  8'd6,  8'd7,  8'd8,
        8'd9,  8'd10, 8'd12, 8'd13, 8'd15, 8'd16, 8'd18, 8'd19,
        8'd21, 8'd23, 8'd25, 8'd26, 8'd28, 8'd30, 8'd33, 8'd35,
        8'd37, 8'd39, 8'd41, 8'd44, 8'd46, 8'd49, 8'd51, 8'd54,
        8'd56, 8'd59, 8'd61, 8'd64, 8'd67, 8'd70, 8'd72, 8'd75,
        8'd78, 8'd81, 8'd84, 8'd87, 8'd90, 8'd93, 8'd96, 8'd99,
        8'd102,8'd105,8'd108,8'd111,8'd115,8'd118,8'd121,8'd124
    };

    // 255 * (255 - ((255 * a) >> 8)) >> 8
    function automatic logic [7:0] fade(input logic [7:0] a);
        logic [15:0] prod;
        logic [7:0]  inv;
        logic [15:0] res;
        prod = ({a, 8'd0} - {8'd0, a});
        inv  = FULL_SCALE - prod[15:8];
        res  = ({inv, 8'd0} - {8'd0, inv});
        return res[15:8];
    endfunction

    function automatic logic [COLOR_W-1:0] hue_to_565(input logic [7:0] h);
        t_sector     sec;
        logic [7:0]  base;
        logic [7:0]  frac;
        logic [10:0] frac6;
        logic [7:0]  rem;
        logic [7:0]  q;
        logic [7:0]  u;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        if (h < 8'd43) begin
            sec = SEC_RED_GREEN;   base = 8'd0;
        end else if (h < 8'd86) begin
            sec = SEC_GREEN_RED;   base = HUE_SECTOR;
        end else if (h < 8'd129) begin
            sec = SEC_GREEN_BLUE;  base = 8'd86;
        end else if (h < 8'd172) begin
            sec = SEC_BLUE_GREEN;  base = 8'd129;
        end else if (h < 8'd215) begin
            sec = SEC_BLUE_RED;    base = 8'd172;
        end else begin
            sec = SEC_RED_BLUE;    base = 8'd215;
        end
        frac  = h - base;
        frac6 = {frac, 2'b00} + {1'b0, frac, 1'b0};
        rem   = frac6[7:0];
        q     = fade(rem);
        u     = fade(FULL_SCALE - rem);
        case (sec)
            SEC_RED_GREEN:  begin r = FULL_SCALE; g = u;          b = 8'd0;       end
            SEC_GREEN_RED:  begin r = q;          g = FULL_SCALE; b = 8'd0;       end
            SEC_GREEN_BLUE: begin r = 8'd0;       g = FULL_SCALE; b = u;          end
            SEC_BLUE_GREEN: begin r = 8'd0;       g = q;          b = FULL_SCALE; end
            SEC_BLUE_RED:   begin r = u;          g = 8'd0;       b = FULL_SCALE; end
            default:        begin r = FULL_SCALE; g = 8'd0;       b = q;          end
        endcase
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage
`default_nettype wire

>>> src/ppg_phase.sv
// phase stage: four sine lookups averaged into a palette index, plus frame-buffer address
`default_nettype none
module ppg_phase (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [ppg_pkg::COORD_W-1:0]      i_x,
    input  wire logic [ppg_pkg::COORD_W-1:0]      i_y,
    input  wire logic [ppg_pkg::TIME_W-1:0]       i_t,
    input  wire logic [ppg_pkg::WIDTH_W-1:0]      i_width,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [7:0]                            o_index,
    output logic [ppg_pkg::ADDR_W-1:0]            o_addr
);

    logic                          r_vld;
    logic [7:0]                    r_index;
    logic [ppg_pkg::ADDR_W-1:0]    r_addr;
    logic [7:0]                    n_index;
    logic [ppg_pkg::ADDR_W-1:0]    n_addr;

    logic [7:0] ph1, ph2, ph3, ph4;
    logic [7:0] t3x;
    logic [7:0] dxy;
    logic [9:0] sum;
    logic [ppg_pkg::WIDTH_W-1:0] w_eff;
    logic [ppg_pkg::PROD_W-1:0]  prod;

    always_comb begin
        t3x   = {i_t[6:0], 1'b0} + i_t[7:0];
        dxy   = i_x - i_y;
        ph1   = {i_x[6:0], 1'b0} + i_x + i_t[7:0];
        ph2   = {i_y[5:0], 2'b00} + i_t[8:1];
        ph3   = {i_x[6:0], 1'b0} + {i_y[6:0], 1'b0} + i_t[9:2];
        ph4   = {dxy[6:0], 1'b0} + t3x;
        sum   = {2'b00, ppg_pkg::SINE_ROM[ph1]} + {2'b00, ppg_pkg::SINE_ROM[ph2]}
              + {2'b00, ppg_pkg::SINE_ROM[ph3]} + {2'b00, ppg_pkg::SINE_ROM[ph4]};
        n_index = sum[9:2];
        w_eff = (i_width > ppg_pkg::MAX_WIDTH) ? ppg_pkg::MAX_WIDTH : i_width;
        prod  = i_y * w_eff;
        n_addr = prod[ppg_pkg::ADDR_W-1:0] + {8'd0, i_x};
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_index <= n_index;
            r_addr  <= n_addr;
        end
    end

    assign o_valid = r_vld;
    assign o_index = r_index;
    assign o_addr  = r_addr;

endmodule
`default_nettype wire

>>> src/ppg_color.sv
// color stage: palette index through the hue wheel into the rgb565 result register
`default_nettype none
module ppg_color (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [7:0]                       i_index,
    input  wire logic [ppg_pkg::ADDR_W-1:0]       i_addr,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [ppg_pkg::COLOR_W-1:0]           o_color,
    output logic [ppg_pkg::ADDR_W-1:0]            o_addr
);

    logic                          r_vld;
    logic [ppg_pkg::COLOR_W-1:0]   r_color;
    logic [ppg_pkg::ADDR_W-1:0]    r_addr;
    logic [ppg_pkg::COLOR_W-1:0]   n_color;

    assign n_color = ppg_pkg::hue_to_565(i_index);
    assign o_ready = !r_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_color <= n_color;
            r_addr  <= i_addr;
        end
    end

    assign o_valid = r_vld;
    assign o_color = r_color;
    assign o_addr  = r_addr;

endmodule
`default_nettype wire

>>> src/plasma_pixel_generator.sv
// plasma pixel generator top level: input register, phase stage and color stage
// usage:
//   input channel: i_pixel_valid / o_pixel_stall carry one word of pixel x, pixel y
//   and frame time; a word is taken on a clock edge with valid high and stall low
//   output channel: o_word_valid / i_word_stall carry the rgb565 color and the
//   frame-buffer address of that pixel, in input order
//   configuration: i_cfg_we writes i_cfg_wdata into the line width register;
//   the user must write it only while no word is in flight; the block does not enforce it
//   path: a word passes the input register, then the index/address register,
//   then the result register, whose valid drives o_word_valid
//   throughput: one word per cycle while i_word_stall is low, set by the three
//   register stages each moving whenever the next stage is empty or moving
//   reset: synchronous, active low; all stages empty, line width back to 240
//   stall: a stalled output holds its word; the stall backs up stage by stage, the
//   two inner stages still filling until o_pixel_stall rises
`default_nettype none
module plasma_pixel_generator (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [ppg_pkg::WIDTH_W-1:0]      i_cfg_wdata,
    input  wire logic                             i_pixel_valid,
    output logic                                  o_pixel_stall,
    input  wire logic [ppg_pkg::COORD_W-1:0]      i_pixel_x,
    input  wire logic [ppg_pkg::COORD_W-1:0]      i_pixel_y,
    input  wire logic [ppg_pkg::TIME_W-1:0]       i_frame_time,
    output logic                                  o_word_valid,
    input  wire logic                             i_word_stall,
    output logic [ppg_pkg::COLOR_W-1:0]           o_pixel_color,
    output logic [ppg_pkg::ADDR_W-1:0]            o_pixel_address
);

    logic [ppg_pkg::WIDTH_W-1:0]   r_width;
    logic                          r_in_vld;
    logic [ppg_pkg::COORD_W-1:0]   r_x;
    logic [ppg_pkg::COORD_W-1:0]   r_y;
    logic [ppg_pkg::TIME_W-1:0]    r_t;

    logic                          in_load;
    logic                          ph_ready;
    logic                          ph_valid;
    logic                          col_ready;
    logic [7:0]                    ph_index;
    logic [ppg_pkg::ADDR_W-1:0]    ph_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= ppg_pkg::WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    assign in_load       = !r_in_vld || ph_ready;
    assign o_pixel_stall = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_load) begin
            r_in_vld <= i_pixel_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_pixel_valid) begin
            r_x <= i_pixel_x;
            r_y <= i_pixel_y;
            r_t <= i_frame_time;
        end
    end

    ppg_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_vld),
        .o_ready (ph_ready),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_t     (r_t),
        .i_width (r_width),
        .o_valid (ph_valid),
        .i_ready (col_ready),
        .o_index (ph_index),
        .o_addr  (ph_addr)
    );

    ppg_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ph_valid),
        .o_ready (col_ready),
        .i_index (ph_index),
        .i_addr  (ph_addr),
        .o_valid (o_word_valid),
        .i_stall (i_word_stall),
        .o_color (o_pixel_color),
        .o_addr  (o_pixel_address)
    );

endmodule
`default_nettype wire
